// ===== design/kenc_pkg.sv =====
`default_nettype none
package kenc_pkg;

	localparam int NUM_KEYS_DEF = 4;

	// restoring divider width, covers the largest encoder accumulation magnitude
	localparam int DIV_BITS = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 3'd0,
		CFG_STEP_TICKS = 3'd1,
		CFG_PEND_LIMIT = 3'd2,
		CFG_DIR_INVERT = 3'd3,
		CFG_BEEP_MS    = 3'd4,
		CFG_ENC_ENABLE = 3'd5
	} cfg_idx_t;

	localparam logic [7:0] DEBOUNCE_RST   = 8'd30;
	localparam logic [7:0] STEP_TICKS_RST = 8'd2;
	localparam logic [6:0] PEND_LIMIT_RST = 7'd32;
	localparam logic [7:0] BEEP_MS_RST    = 8'd18;

	localparam logic CMD_KEY_EDGE = 1'b0;
	localparam logic CMD_POLL     = 1'b1;

	localparam logic [1:0] CODE_PREV  = 2'd0;
	localparam logic [1:0] CODE_NEXT  = 2'd1;
	localparam logic [1:0] CODE_ENTER = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic [31:0]        now_ms;
		logic [1:0]         key_index;
		logic [3:0]         key_levels;
		logic signed [15:0] encoder_delta;
	} in_t;

	typedef struct packed {
		logic       pressed;
		logic [1:0] key_code;
		logic       beep_on;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// ===== design/key_encoder_event_controller.sv =====
// key edge: taken in the idle state, which it does not leave; gives no result
// poll: result lands in the output register after the divide, apply and emit states; the divide
//   state runs the 16 one-bit iterations of the compare/subtract divider, emit waits on out_stall
// input stall is high from a poll's transfer until its result is loaded
// reset (arst_n low, asynchronous): registers to defaults, press times, latches, queues cleared
`default_nettype none
module key_encoder_event_controller #(
	parameter int NUM_KEYS = kenc_pkg::NUM_KEYS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  kenc_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output kenc_pkg::out_t                     out_data,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [kenc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [kenc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int DW = kenc_pkg::DIV_BITS;
	localparam int CW = $clog2(DW);

	// configuration registers
	logic [7:0] debounce_q;
	logic [7:0] step_ticks_q;
	logic [6:0] pend_limit_q;
	logic       dir_invert_q;
	logic [7:0] beep_ms_q;
	logic       enc_enable_q;

	// block state
	logic [31:0]         press_time_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] latched_q;
	logic [NUM_KEYS-1:0] pending_keys_q;
	logic signed [8:0]   step_rem_q;
	logic signed [7:0]   pend_steps_q;
	logic [1:0]          prev_code_q;
	logic                release_due_q;
	logic                beep_active_q;
	logic [31:0]         beep_end_q;

	// sequencer and divider
	kenc_pkg::state_t state_q;
	logic [CW-1:0]    div_cnt_q;
	logic [7:0]       divisor_q;
	logic [7:0]       div_rem_q;
	logic [DW-1:0]    div_quo_q;
	logic             acc_neg_q;
	logic             acc_en_q;
	logic [31:0]      now_q;

	logic           out_valid_q;
	kenc_pkg::out_t out_data_q;

	assign in_stall  = (state_q != kenc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	logic in_xfer;
	logic out_free;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// key edge qualification
	logic [KIW-1:0]      key_sel;
	logic                key_in_range;
	logic [NUM_KEYS-1:0] key_mask;
	logic [NUM_KEYS-1:0] levels_ext;
	logic [31:0]         since_press;
	logic                edge_ok;

	assign key_sel      = KIW'(in_data.key_index);
	assign key_in_range = (32'(in_data.key_index) < 32'(NUM_KEYS));
	assign key_mask     = NUM_KEYS'(1) << in_data.key_index;
	assign levels_ext   = NUM_KEYS'(in_data.key_levels);
	assign since_press  = in_data.now_ms - (key_in_range ? press_time_q[key_sel] : 32'd0);
	assign edge_ok      = key_in_range && ((latched_q & key_mask) == '0) &&
		(since_press >= {24'd0, debounce_q}) && ((levels_ext & key_mask) == '0);

	// encoder accumulation ahead of the divider
	logic signed [16:0] delta_ext;
	logic signed [16:0] delta_eff;
	logic signed [17:0] acc;
	logic [17:0]        acc_mag;
	logic [31:0]        beep_left;

	assign delta_ext = 17'(in_data.encoder_delta);
	assign delta_eff = dir_invert_q ? -delta_ext : delta_ext;
	assign acc       = 18'(step_rem_q) + 18'(delta_eff);
	assign acc_mag   = acc[17] ? 18'(-acc) : 18'(acc);
	assign beep_left = in_data.now_ms - beep_end_q;

	// one restoring division step
	logic [8:0] trial;
	logic [8:0] trial_sub;
	logic       trial_ge;

	assign trial     = {div_rem_q, div_quo_q[DW-1]};
	assign trial_ge  = (trial >= {1'b0, divisor_q});
	assign trial_sub = trial - {1'b0, divisor_q};

	// saturating update of the step queue
	logic signed [17:0] p_ext;
	logic signed [17:0] q_ext;
	logic signed [17:0] lim_ext;
	logic signed [17:0] nlim_ext;
	logic signed [17:0] p_sum;
	logic signed [17:0] p_diff;
	logic signed [8:0]  rem_pos;

	assign p_ext    = 18'(pend_steps_q);
	assign q_ext    = $signed({2'b00, div_quo_q});
	assign lim_ext  = $signed({11'd0, pend_limit_q});
	assign nlim_ext = -lim_ext;
	assign p_sum    = p_ext + q_ext;
	assign p_diff   = p_ext - q_ext;
	assign rem_pos  = $signed({1'b0, div_rem_q});

	// lowest pending key
	logic           key_found;
	logic [KIW-1:0] key_pick;

	always_comb begin
		key_found = 1'b0;
		key_pick  = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (pending_keys_q[i]) begin
				key_found = 1'b1;
				key_pick  = KIW'(i);
			end
		end
	end

	// result of the emit step: a due release first, then encoder steps, then keys
	logic           emit_found;
	logic           emit_press;
	logic [1:0]     emit_code;
	kenc_pkg::out_t emit_data;

	always_comb begin
		emit_found = (pend_steps_q != 8'sd0) || key_found;
		if (pend_steps_q > 8'sd0) begin
			emit_code = kenc_pkg::CODE_NEXT;
		end else if (pend_steps_q < 8'sd0) begin
			emit_code = kenc_pkg::CODE_PREV;
		end else begin
			emit_code = 2'(key_pick);
		end
		emit_press         = !release_due_q && emit_found;
		emit_data.pressed  = emit_press;
		emit_data.key_code = emit_press ? emit_code : prev_code_q;
		emit_data.beep_on  = emit_press || beep_active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= kenc_pkg::DEBOUNCE_RST;
			step_ticks_q   <= kenc_pkg::STEP_TICKS_RST;
			pend_limit_q   <= kenc_pkg::PEND_LIMIT_RST;
			dir_invert_q   <= 1'b0;
			beep_ms_q      <= kenc_pkg::BEEP_MS_RST;
			enc_enable_q   <= 1'b1;
			for (int i = 0; i < NUM_KEYS; i++) begin
				press_time_q[i] <= '0;
			end
			latched_q      <= '0;
			pending_keys_q <= '0;
			step_rem_q     <= '0;
			pend_steps_q   <= '0;
			prev_code_q    <= kenc_pkg::CODE_ENTER;
			release_due_q  <= 1'b0;
			beep_active_q  <= 1'b0;
			beep_end_q     <= '0;
			state_q        <= kenc_pkg::ST_IDLE;
			div_cnt_q      <= '0;
			divisor_q      <= '0;
			div_rem_q      <= '0;
			div_quo_q      <= '0;
			acc_neg_q      <= 1'b0;
			acc_en_q       <= 1'b0;
			now_q          <= '0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else begin
			// the user is to write registers only while the block is idle; the block itself does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					kenc_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data;
					kenc_pkg::CFG_STEP_TICKS: step_ticks_q <= cfg_data;
					kenc_pkg::CFG_PEND_LIMIT: pend_limit_q <= cfg_data[6:0];
					kenc_pkg::CFG_DIR_INVERT: dir_invert_q <= cfg_data[0];
					kenc_pkg::CFG_BEEP_MS:    beep_ms_q    <= cfg_data;
					kenc_pkg::CFG_ENC_ENABLE: enc_enable_q <= cfg_data[0];
					default: ;
				endcase
			end

			// the emit step reloads the output register itself
			if (out_valid_q && !out_stall && state_q != kenc_pkg::ST_EMIT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				kenc_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.cmd == kenc_pkg::CMD_KEY_EDGE) begin
							// debounced press gets latched until the pin reads high
							if (edge_ok) begin
								press_time_q[key_sel] <= in_data.now_ms;
								pending_keys_q        <= pending_keys_q | key_mask;
								latched_q             <= latched_q | key_mask;
							end
						end else begin
							// beep ends once its end time is reached
							if (beep_active_q && !beep_left[31]) begin
								beep_active_q <= 1'b0;
							end
							latched_q <= latched_q & ~levels_ext;
							acc_en_q  <= enc_enable_q && (in_data.encoder_delta != 16'sd0);
							acc_neg_q <= acc[17];
							divisor_q <= (step_ticks_q == 8'd0) ? 8'd1 : step_ticks_q;
							div_rem_q <= '0;
							div_quo_q <= acc_mag[DW-1:0];
							div_cnt_q <= CW'(DW - 1);
							now_q     <= in_data.now_ms;
							state_q   <= kenc_pkg::ST_DIV;
						end
					end
				end
				kenc_pkg::ST_DIV: begin
					// magnitude bits shift out the top, quotient bits in at the bottom
					div_rem_q <= trial_ge ? trial_sub[7:0] : trial[7:0];
					div_quo_q <= {div_quo_q[DW-2:0], trial_ge};
					div_cnt_q <= div_cnt_q - CW'(1);
					if (div_cnt_q == '0) begin
						state_q <= kenc_pkg::ST_APPLY;
					end
				end
				kenc_pkg::ST_APPLY: begin
					if (acc_en_q) begin
						step_rem_q <= acc_neg_q ? -rem_pos : rem_pos;
						// a count already past the limit holds in that direction
						if (!acc_neg_q && (div_quo_q != '0) && (p_ext < lim_ext)) begin
							pend_steps_q <= (p_sum > lim_ext) ? lim_ext[7:0] : p_sum[7:0];
						end else if (acc_neg_q && (div_quo_q != '0) && (p_ext > nlim_ext)) begin
							pend_steps_q <= (p_diff < nlim_ext) ? nlim_ext[7:0] : p_diff[7:0];
						end
					end
					state_q <= kenc_pkg::ST_EMIT;
				end
				kenc_pkg::ST_EMIT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_data_q    <= emit_data;
						release_due_q <= emit_press;
						if (emit_press) begin
							// encoder steps outrank keys
							beep_active_q <= 1'b1;
							beep_end_q    <= now_q + {24'd0, beep_ms_q};
							prev_code_q   <= emit_code;
							if (pend_steps_q > 8'sd0) begin
								pend_steps_q <= pend_steps_q - 8'sd1;
							end else if (pend_steps_q < 8'sd0) begin
								pend_steps_q <= pend_steps_q + 8'sd1;
							end else begin
								pending_keys_q[key_pick] <= 1'b0;
							end
						end
						state_q <= kenc_pkg::ST_IDLE;
					end
				end
				default: state_q <= kenc_pkg::ST_IDLE;
			endcase
		end
	end

	// a result is only loaded at the end of a poll
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == kenc_pkg::ST_EMIT))
		else $error("result appeared outside the emit step");

	// a reported press always leaves its release queued
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && out_data.pressed) |-> release_due_q)
		else $error("press reported without a queued release");

	// the step queue never reaches the unused negative code
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_steps_q != -8'sd128)
		else $error("step queue out of range");

endmodule
`default_nettype wire

// ===== tb/tb_key_encoder_event_controller.sv =====
`default_nettype none
module tb_key_encoder_event_controller;

	localparam int NUM_KEYS = kenc_pkg::NUM_KEYS_DEF;
	// quiet cycles (no transfer on any channel) before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// cycles let pass after the last result, covers a key edge still in flight
	localparam int SETTLE_CYCLES = 40;
	// index that decodes to no register, writes to it must be harmless
	localparam logic [kenc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	logic in_valid;
	logic in_stall;
	kenc_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	kenc_pkg::out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [kenc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kenc_pkg::CFG_DATA_W-1:0] cfg_data;

	key_encoder_event_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// key edges and polls waiting to be offered, and the events still owed by the block
	kenc_pkg::in_t key_poll_items[$];
	kenc_pkg::out_t expected_events[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit in_taken = 1'b0;
	logic [31:0] clock_ms;

	// controller registers as the block should hold them
	logic [7:0] debounce_ms;
	logic [7:0] step_ticks;
	logic [6:0] pend_limit;
	logic dir_invert;
	logic [7:0] beep_ms;
	logic enc_enable;

	// keypad, encoder and buzzer state of the predictor
	logic [31:0] press_time[NUM_KEYS];
	logic [NUM_KEYS-1:0] latched_keys;
	logic [NUM_KEYS-1:0] pending_keys;
	int step_rem;
	int step_count;
	logic [1:0] prev_code;
	bit release_owed;
	bit beep_active;
	logic [31:0] beep_end;

	function automatic void reset_controller();
		debounce_ms = kenc_pkg::DEBOUNCE_RST;
		step_ticks = kenc_pkg::STEP_TICKS_RST;
		pend_limit = kenc_pkg::PEND_LIMIT_RST;
		dir_invert = 1'b0;
		beep_ms = kenc_pkg::BEEP_MS_RST;
		enc_enable = 1'b1;
		for (int i = 0; i < NUM_KEYS; i++) press_time[i] = '0;
		latched_keys = '0;
		pending_keys = '0;
		step_rem = 0;
		step_count = 0;
		prev_code = kenc_pkg::CODE_ENTER;
		release_owed = 1'b0;
		beep_active = 1'b0;
		beep_end = '0;
	endfunction

	function automatic void set_register(input logic [kenc_pkg::CFG_IDX_W-1:0] idx,
			input logic [kenc_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			kenc_pkg::CFG_DEBOUNCE: debounce_ms = val;
			kenc_pkg::CFG_STEP_TICKS: step_ticks = val;
			kenc_pkg::CFG_PEND_LIMIT: pend_limit = val[6:0];
			kenc_pkg::CFG_DIR_INVERT: dir_invert = val[0];
			kenc_pkg::CFG_BEEP_MS: beep_ms = val;
			kenc_pkg::CFG_ENC_ENABLE: enc_enable = val[0];
			default: ;
		endcase
	endfunction

	// whole steps go to the saturating count, the leftover counts stay in step_rem
	function automatic void step_encoder(input int delta);
		int step;
		int lim;
		int acc;
		int n;
		step = (step_ticks == 8'd0) ? 1 : int'(step_ticks);
		lim = int'(pend_limit);
		acc = step_rem + delta;
		if (acc >= step) begin
			n = acc / step;
			acc = acc - n * step;
			// a count already past a lowered limit is kept, not grown
			if (step_count < lim) begin
				step_count = step_count + n;
				if (step_count > lim) step_count = lim;
			end
		end else if (acc <= -step) begin
			n = (-acc) / step;
			acc = acc + n * step;
			if (step_count > -lim) begin
				step_count = step_count - n;
				if (step_count < -lim) step_count = -lim;
			end
		end
		step_rem = acc;
	endfunction

	// returns 1 when the item yields a ui event, which is then placed in ev
	function automatic bit predict_event(input kenc_pkg::in_t item,
			output kenc_pkg::out_t ev);
		logic [31:0] age;
		int delta;
		bit found;
		logic [1:0] code;
		ev = '0;
		if (item.cmd == kenc_pkg::CMD_KEY_EDGE) begin
			// debounce: latch clear, wrapping age long enough, pin low
			age = item.now_ms - press_time[item.key_index];
			if (!latched_keys[item.key_index] && age >= {24'd0, debounce_ms} &&
					!item.key_levels[item.key_index]) begin
				press_time[item.key_index] = item.now_ms;
				pending_keys[item.key_index] = 1'b1;
				latched_keys[item.key_index] = 1'b1;
			end
			return 1'b0;
		end
		age = item.now_ms - beep_end;
		if (beep_active && !age[31]) beep_active = 1'b0;
		latched_keys = latched_keys & ~item.key_levels;
		delta = item.encoder_delta;
		if (enc_enable && delta != 0) begin
			if (dir_invert) delta = -delta;
			step_encoder(delta);
		end
		found = 1'b0;
		code = kenc_pkg::CODE_PREV;
		if (release_owed) begin
			release_owed = 1'b0;
		end else begin
			// encoder steps win over keys, lowest key index first
			if (step_count > 0) begin
				step_count--;
				code = kenc_pkg::CODE_NEXT;
				found = 1'b1;
			end else if (step_count < 0) begin
				step_count++;
				code = kenc_pkg::CODE_PREV;
				found = 1'b1;
			end else begin
				for (int i = 0; i < NUM_KEYS; i++) begin
					if (!found && pending_keys[i]) begin
						pending_keys[i] = 1'b0;
						code = 2'(i);
						found = 1'b1;
					end
				end
			end
			if (found) begin
				prev_code = code;
				release_owed = 1'b1;
				beep_active = 1'b1;
				beep_end = item.now_ms + {24'd0, beep_ms};
			end
		end
		ev.pressed = found;
		ev.key_code = prev_code;
		ev.beep_on = beep_active;
		return 1'b1;
	endfunction

	function automatic kenc_pkg::in_t key_edge(input logic [1:0] k, input logic [31:0] t,
			input logic [3:0] lv);
		kenc_pkg::in_t it;
		it.cmd = kenc_pkg::CMD_KEY_EDGE;
		it.now_ms = t;
		it.key_index = k;
		it.key_levels = lv;
		// encoder field is don't-care on a key edge
		it.encoder_delta = 16'($urandom);
		return it;
	endfunction

	function automatic kenc_pkg::in_t poll_item(input logic [31:0] t, input logic [3:0] lv,
			input logic [15:0] d);
		kenc_pkg::in_t it;
		it.cmd = kenc_pkg::CMD_POLL;
		it.now_ms = t;
		it.key_index = 2'($urandom);
		it.key_levels = lv;
		it.encoder_delta = d;
		return it;
	endfunction

	// ---------------------------------------------------------------
	// input driver: offers the next queued item at the falling edge,
	// holds a stalled item until its transfer has been seen
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drive_items
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (key_poll_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_data <= key_poll_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------
	// monitor: predicts on each input transfer, checks each result
	// transfer against the oldest owed event, tracks register writes
	// ---------------------------------------------------------------
	always @(posedge clk) begin : observe
		kenc_pkg::out_t want;
		bit busy;
		if (arst_n) begin
			busy = 1'b0;
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				busy = 1'b1;
				if (predict_event(in_data, want)) expected_events.push_back(want);
			end
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (expected_events.size() == 0) begin
					mismatches++;
					$display("%0t unexpected event: pressed=%0d key_code=%0d beep_on=%0d",
						$time, out_data.pressed, out_data.key_code, out_data.beep_on);
				end else begin
					want = expected_events.pop_front();
					if (out_data.pressed !== want.pressed ||
							out_data.key_code !== want.key_code ||
							out_data.beep_on !== want.beep_on) begin
						mismatches++;
						$display({"%0t event mismatch: expected pressed=%0d key_code=%0d",
							" beep_on=%0d, got pressed=%0d key_code=%0d beep_on=%0d"},
							$time, want.pressed, want.key_code, want.beep_on,
							out_data.pressed, out_data.key_code, out_data.beep_on);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				set_register(cfg_index, cfg_data);
			end
			quiet_cycles <= busy ? 0 : quiet_cycles + 1;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (quiet_cycles < HANG_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// one register write transfer, issued only while the block is idle
	task automatic write_register(input logic [kenc_pkg::CFG_IDX_W-1:0] idx,
			input logic [kenc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every queued item is taken and every event is back
	task automatic wait_drained();
		do @(posedge clk);
		while (key_poll_items.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// realistic traffic: time creeps forward, edges mostly on low pins,
	// polls mostly with small encoder motion, some wild values mixed in
	task automatic queue_random_traffic(input int count);
		logic [1:0] k;
		logic [3:0] lv;
		logic [15:0] d;
		int r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
			r = $urandom_range(0, 99);
			if (r < 45) begin
				k = 2'($urandom);
				lv = 4'($urandom);
				if ($urandom_range(0, 3) != 0) lv[k] = 1'b0;
				clock_ms = clock_ms + $urandom_range(0, 80);
				key_poll_items.push_back(key_edge(k, clock_ms, lv));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) lv = 4'hF;
				else if (r < 60) lv = 4'h0;
				else lv = 4'($urandom);
				r = $urandom_range(0, 99);
				if (r < 15) d = 16'd0;
				else if (r < 70) d = 16'(int'($urandom_range(0, 16)) - 8);
				else if (r < 90) d = 16'(int'($urandom_range(0, 4000)) - 2000);
				else d = 16'($urandom);
				clock_ms = clock_ms + $urandom_range(0, 40);
				key_poll_items.push_back(poll_item(clock_ms, lv, d));
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random_traffic(count);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clock_ms = 32'd10;
		reset_controller();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings, no idling
		// poll with nothing to report gives a release of the enter code
		key_poll_items.push_back(poll_item(32'd0, 4'hF, 16'd0));
		// rejected: too soon after time zero, then pin high; taken once the pin reads low
		key_poll_items.push_back(key_edge(2'd0, 32'd10, 4'h0));
		key_poll_items.push_back(key_edge(2'd0, 32'd40, 4'h1));
		key_poll_items.push_back(key_edge(2'd0, 32'd40, 4'hE));
		// key 0 rejected while latched, keys 1 to 3 taken
		key_poll_items.push_back(key_edge(2'd0, 32'd100, 4'h0));
		key_poll_items.push_back(key_edge(2'd1, 32'd100, 4'h0));
		key_poll_items.push_back(key_edge(2'd2, 32'd100, 4'h0));
		key_poll_items.push_back(key_edge(2'd3, 32'd100, 4'h0));
		// drain the four keys: press and release each in index order
		for (int i = 0; i < 8; i++)
			key_poll_items.push_back(poll_item(32'd101 + i, 4'h0, 16'd0));
		// beep ends, latches clear, one step forward
		key_poll_items.push_back(poll_item(32'd200, 4'hF, 16'd3));
		// encoder extremes saturate in both directions
		key_poll_items.push_back(poll_item(32'd201, 4'hF, 16'h8000));
		key_poll_items.push_back(poll_item(32'd202, 4'hF, 16'h7FFF));
		key_poll_items.push_back(poll_item(32'd203, 4'hF, 16'd0));
		// beep end time wraps past zero
		key_poll_items.push_back(poll_item(32'hFFFF_FFF0, 4'hF, 16'hFFFF));
		key_poll_items.push_back(key_edge(2'd2, 32'hFFFF_FFFF, 4'hB));
		key_poll_items.push_back(poll_item(32'hFFFF_FFFF, 4'h0, 16'd0));
		key_poll_items.push_back(poll_item(32'd5, 4'hF, 16'd0));
		wait_drained();

		// limit lowered below the steps still queued, zero step size
		write_register(kenc_pkg::CFG_DEBOUNCE, 8'd0);
		write_register(kenc_pkg::CFG_STEP_TICKS, 8'd0);
		write_register(kenc_pkg::CFG_PEND_LIMIT, 8'd1);
		write_register(kenc_pkg::CFG_DIR_INVERT, 8'd1);
		write_register(kenc_pkg::CFG_BEEP_MS, 8'd255);
		write_register(CFG_UNUSED, 8'hFF);
		run_phase(51, 0, 19);

		// upper extremes, zero beep time, encoder off
		write_register(kenc_pkg::CFG_DEBOUNCE, 8'd255);
		write_register(kenc_pkg::CFG_STEP_TICKS, 8'd255);
		write_register(kenc_pkg::CFG_PEND_LIMIT, 8'd127);
		write_register(kenc_pkg::CFG_DIR_INVERT, 8'd0);
		write_register(kenc_pkg::CFG_BEEP_MS, 8'd0);
		write_register(kenc_pkg::CFG_ENC_ENABLE, 8'd0);
		run_phase(0, 51, 19);

		// random settings, bits above each register width included
		write_register(kenc_pkg::CFG_DEBOUNCE, 8'($urandom));
		write_register(kenc_pkg::CFG_STEP_TICKS, 8'($urandom));
		write_register(kenc_pkg::CFG_PEND_LIMIT, 8'($urandom));
		write_register(kenc_pkg::CFG_DIR_INVERT, 8'($urandom));
		write_register(kenc_pkg::CFG_BEEP_MS, 8'($urandom));
		write_register(kenc_pkg::CFG_ENC_ENABLE, 8'($urandom));
		run_phase(24, 24, 19);

		write_register(kenc_pkg::CFG_DEBOUNCE, 8'd30);
		write_register(kenc_pkg::CFG_STEP_TICKS, 8'd1);
		write_register(kenc_pkg::CFG_PEND_LIMIT, 8'hFF);
		write_register(kenc_pkg::CFG_DIR_INVERT, 8'hFE);
		write_register(kenc_pkg::CFG_BEEP_MS, 8'h80);
		write_register(kenc_pkg::CFG_ENC_ENABLE, 8'hFF);
		run_phase(0, 0, 19);

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
